### hw/rtl/bdl_pkg.sv
`default_nettype none

package bdl_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned DistW  = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned StatW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_FIND_FWD  = 3'd3,
    CMD_FIND_BWD  = 3'd4
  } bdl_cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BADPOS   = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } bdl_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } bdl_state_e;

  // Control of the ring store for one cycle.
  typedef struct packed {
    logic wr_en;
    logic push_front;
    logic rd_en;
  } bdl_ring_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/bounded_double_ended_list.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a ring-addressed
// single-port-read RAM. One command is taken at a time: inserts at either end
// go straight to the completion state, a search walks the entries one RAM read
// per cycle and finishes on the first match or at the last entry, and a delete
// at position p copies each later entry down by one (no copying when the last
// entry is removed). The single RAM read port sets the pace of these walks. No
// clearing pass is needed after reset, and a finished result may wait in the
// output register while the next command is already being worked on.
module bounded_double_ended_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [bdl_pkg::CmdW-1:0]       command_i,
  input  wire logic signed [bdl_pkg::DataW-1:0] value_i,
  input  wire logic [bdl_pkg::PosW-1:0]       position_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [bdl_pkg::StatW-1:0]      status_o,
  output logic      [bdl_pkg::DistW-1:0]      match_distance_o,
  output logic      [bdl_pkg::CountW-1:0]     entry_count_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > bdl_pkg::PosW) ? CntW : bdl_pkg::PosW;
  localparam int unsigned OutW = (CntW > bdl_pkg::CountW) ? CntW : bdl_pkg::CountW;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  bdl_pkg::bdl_state_e       state_q, state_d;
  logic [CntW-1:0]           len_q, len_d;
  logic [bdl_pkg::DataW-1:0] key_q, key_d;
  logic                      bwd_q, bwd_d;
  logic [CntW-1:0]           iss_q, iss_d;
  logic [CntW-1:0]           chk_q, chk_d;
  logic                      rd_vld_q, rd_vld_d;
  bdl_pkg::bdl_status_e      res_status_q, res_status_d;
  logic [bdl_pkg::DistW-1:0] res_dist_q, res_dist_d;
  logic                      out_valid_q, out_valid_d;
  logic [bdl_pkg::StatW-1:0] out_status_q, out_status_d;
  logic [bdl_pkg::DistW-1:0] out_dist_q, out_dist_d;
  logic [bdl_pkg::CountW-1:0] out_count_q, out_count_d;

  bdl_pkg::bdl_cmd_e         cmd;
  bdl_pkg::bdl_ring_ctrl_t   ring_ctrl;
  logic [IdxW-1:0]           wr_idx;
  logic [bdl_pkg::DataW-1:0] wr_data;
  logic [IdxW-1:0]           rd_idx;
  logic [bdl_pkg::DataW-1:0] rd_data;

  logic [CmpW-1:0]           pos_ext;
  logic [CmpW-1:0]           len_ext;
  logic [CmpW-1:0]           chk_ext;
  logic [OutW-1:0]           len_out;
  logic [CntW-1:0]           last_idx;
  logic [CntW-1:0]           back_idx;
  logic [CntW-1:0]           prev_idx;
  logic                      list_full;
  logic                      list_empty;
  logic                      del_walk;
  logic                      hit;
  logic                      at_last;
  logic                      search_fin;
  logic                      shift_fin;
  logic                      out_free;

  always_comb begin
    cmd        = bdl_pkg::bdl_cmd_e'(command_i);
    pos_ext    = CmpW'(position_i);
    len_ext    = CmpW'(len_q);
    chk_ext    = CmpW'(chk_q);
    len_out    = OutW'(len_q);
    last_idx   = len_q - CntW'(1);
    back_idx   = last_idx - iss_q;
    prev_idx   = chk_q - CntW'(1);
    list_full  = (len_q == CapC);
    list_empty = (len_q == '0);
    // A delete of the last entry needs no copying.
    del_walk   = !list_empty && (pos_ext < len_ext) && (pos_ext != CmpW'(last_idx));
    // Only a search compares against the key; a delete walk never stops early.
    hit        = rd_vld_q && (state_q == bdl_pkg::ST_SEARCH) && (rd_data == key_q);
    at_last    = rd_vld_q && (chk_q == last_idx);
    search_fin = hit || at_last;
    shift_fin  = at_last;
    out_free   = !out_valid_q || !out_stall_i;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bdl_pkg::ST_DONE;
          case (cmd)
            bdl_pkg::CMD_DELETE: begin
              if (del_walk) begin
                state_d = bdl_pkg::ST_SHIFT;
              end
            end
            bdl_pkg::CMD_FIND_FWD, bdl_pkg::CMD_FIND_BWD: begin
              if (!list_empty) begin
                state_d = bdl_pkg::ST_SEARCH;
              end
            end
            default: state_d = bdl_pkg::ST_DONE;
          endcase
        end
      end
      bdl_pkg::ST_SEARCH: begin
        if (search_fin) begin
          state_d = bdl_pkg::ST_DONE;
        end
      end
      bdl_pkg::ST_SHIFT: begin
        if (shift_fin) begin
          state_d = bdl_pkg::ST_DONE;
        end
      end
      bdl_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bdl_pkg::ST_IDLE;
        end
      end
      default: state_d = bdl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    len_d        = len_q;
    key_d        = key_q;
    bwd_d        = bwd_q;
    iss_d        = iss_q;
    chk_d        = chk_q;
    rd_vld_d     = 1'b0;
    res_status_d = res_status_q;
    res_dist_d   = res_dist_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_dist_d   = out_dist_q;
    out_count_d  = out_count_q;
    ring_ctrl    = '0;
    wr_idx       = '0;
    wr_data      = '0;
    rd_idx       = '0;

    case (state_q)
      bdl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = bdl_pkg::STAT_OK;
          res_dist_d   = '0;
          case (cmd)
            bdl_pkg::CMD_INS_FRONT, bdl_pkg::CMD_INS_BACK: begin
              if (list_full) begin
                res_status_d = bdl_pkg::STAT_FULL;
              end else begin
                ring_ctrl.wr_en      = 1'b1;
                ring_ctrl.push_front = (cmd == bdl_pkg::CMD_INS_FRONT);
                wr_idx               = len_q[IdxW-1:0];
                wr_data              = $unsigned(value_i);
                len_d                = len_q + CntW'(1);
              end
            end
            bdl_pkg::CMD_DELETE: begin
              bwd_d = 1'b0;
              if (list_empty) begin
                res_status_d = bdl_pkg::STAT_EMPTY;
              end else if (pos_ext >= len_ext) begin
                res_status_d = bdl_pkg::STAT_BADPOS;
              end else if (!del_walk) begin
                len_d = last_idx;
              end else begin
                iss_d = CntW'(pos_ext + CmpW'(1));
              end
            end
            bdl_pkg::CMD_FIND_FWD, bdl_pkg::CMD_FIND_BWD: begin
              key_d = $unsigned(value_i);
              bwd_d = (cmd == bdl_pkg::CMD_FIND_BWD);
              iss_d = '0;
              if (list_empty) begin
                res_status_d = bdl_pkg::STAT_EMPTY;
              end
            end
            default: res_status_d = bdl_pkg::STAT_OK;
          endcase
        end
      end
      bdl_pkg::ST_SEARCH, bdl_pkg::ST_SHIFT: begin
        if (state_q == bdl_pkg::ST_SEARCH) begin
          if (hit) begin
            res_dist_d = chk_ext[bdl_pkg::DistW-1:0];
          end else if (at_last) begin
            res_status_d = bdl_pkg::STAT_NOTFOUND;
          end
        end else if (rd_vld_q) begin
          // Entry read last cycle moves down by one place.
          ring_ctrl.wr_en = 1'b1;
          wr_idx          = prev_idx[IdxW-1:0];
          wr_data         = rd_data;
          if (shift_fin) begin
            len_d = last_idx;
          end
        end
        if ((iss_q < len_q) && !search_fin) begin
          ring_ctrl.rd_en = 1'b1;
          rd_idx          = bwd_q ? back_idx[IdxW-1:0] : iss_q[IdxW-1:0];
          iss_d           = iss_q + CntW'(1);
          chk_d           = iss_q;
          rd_vld_d        = 1'b1;
        end
      end
      bdl_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_dist_d   = res_dist_q;
          out_count_d  = len_out[bdl_pkg::CountW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdl_pkg::ST_IDLE;
      len_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    bwd_q        <= bwd_d;
    iss_q        <= iss_d;
    chk_q        <= chk_d;
    res_status_q <= res_status_d;
    res_dist_q   <= res_dist_d;
    out_status_q <= out_status_d;
    out_dist_q   <= out_dist_d;
    out_count_q  <= out_count_d;
  end

  bdl_ring #(
    .CAPACITY (CAPACITY)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ring_ctrl),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  assign in_stall_o       = (state_q != bdl_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign match_distance_o = out_dist_q;
  assign entry_count_o    = out_count_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CapC)
    else $error("entry count exceeds capacity");

  a_read_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == bdl_pkg::ST_SEARCH || state_q == bdl_pkg::ST_SHIFT))
    else $error("read data pending outside a walk");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !list_full &&
     (cmd == bdl_pkg::CMD_INS_FRONT || cmd == bdl_pkg::CMD_INS_BACK))
    |=> len_q == $past(len_q) + CntW'(1))
    else $error("insert did not add an entry");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |-> $past(state_q) == bdl_pkg::ST_DONE)
    else $error("result produced outside the completion state");

  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> chk_q < len_q)
    else $error("walk read beyond the last entry");

endmodule

`default_nettype wire

### hw/rtl/bdl_ring.sv
`default_nettype none

module bdl_ring #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned IdxW = $clog2(CAPACITY)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bdl_pkg::bdl_ring_ctrl_t     ctrl_i,
  input  wire logic [IdxW-1:0]             wr_idx_i,
  input  wire logic [bdl_pkg::DataW-1:0]   wr_data_i,
  input  wire logic [IdxW-1:0]             rd_idx_i,
  output logic      [bdl_pkg::DataW-1:0]   rd_data_o
);

  localparam logic [IdxW:0] CapL = (IdxW+1)'(CAPACITY);

  logic [bdl_pkg::DataW-1:0] mem [CAPACITY];
  logic [bdl_pkg::DataW-1:0] rd_data_q;
  logic [IdxW-1:0]           head_q, head_d;
  logic [IdxW-1:0]           head_dec;
  logic [IdxW-1:0]           waddr;
  logic [IdxW-1:0]           raddr;

  // Logical positions are offsets from the head; the sum stays below twice the capacity.
  function automatic logic [IdxW-1:0] wrap(input logic [IdxW-1:0] base,
                                           input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CapL) begin
      sum = sum - CapL;
    end
    return sum[IdxW-1:0];
  endfunction

  always_comb begin
    head_dec = (head_q == '0) ? IdxW'(CAPACITY - 1) : head_q - 1'b1;
    waddr    = ctrl_i.push_front ? head_dec : wrap(head_q, wr_idx_i);
    raddr    = wrap(head_q, rd_idx_i);
    head_d   = (ctrl_i.wr_en && ctrl_i.push_front) ? head_dec : head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### dv/bounded_double_ended_list_tb.sv
`timescale 1ns / 1ps

module bounded_double_ended_list_tb;

  localparam int unsigned LIST_CAP       = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned PHASE_ITEMS    = 330;

  typedef struct packed {
    logic [bdl_pkg::StatW-1:0]  status;
    logic [bdl_pkg::DistW-1:0]  distance;
    logic [bdl_pkg::CountW-1:0] count;
  } list_result_t;

  logic                             clk_i;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic [bdl_pkg::CmdW-1:0]         command_i    = '0;
  logic signed [bdl_pkg::DataW-1:0] value_i      = '0;
  logic [bdl_pkg::PosW-1:0]         position_i   = '0;
  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic [bdl_pkg::StatW-1:0]        status_o;
  logic [bdl_pkg::DistW-1:0]        match_distance_o;
  logic [bdl_pkg::CountW-1:0]       entry_count_o;

  // Shadow copy of the list contents, front at index 0.
  logic [bdl_pkg::DataW-1:0] list_shadow[$];
  list_result_t              pending_results[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatch_count     = 0;
  int unsigned quiet_cycles       = 0;
  bit          grow_mode          = 1'b1;

  bounded_double_ended_list #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .match_distance_o(match_distance_o),
    .entry_count_o   (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one command to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_cmd(input logic [bdl_pkg::CmdW-1:0] cmd,
                                                  input logic [bdl_pkg::DataW-1:0] val,
                                                  input logic [bdl_pkg::PosW-1:0] pos);
    list_result_t res;
    int unsigned  len;
    bit           hit;
    res.status   = bdl_pkg::STAT_OK;
    res.distance = '0;
    len          = list_shadow.size();
    hit          = 1'b0;
    case (cmd)
      bdl_pkg::CMD_INS_FRONT: begin
        if (len >= LIST_CAP) res.status = bdl_pkg::STAT_FULL;
        else list_shadow.push_front(val);
      end
      bdl_pkg::CMD_INS_BACK: begin
        if (len >= LIST_CAP) res.status = bdl_pkg::STAT_FULL;
        else list_shadow.push_back(val);
      end
      bdl_pkg::CMD_DELETE: begin
        if (len == 0) res.status = bdl_pkg::STAT_EMPTY;
        else if (pos >= len) res.status = bdl_pkg::STAT_BADPOS;
        else list_shadow.delete(int'(pos));
      end
      bdl_pkg::CMD_FIND_FWD, bdl_pkg::CMD_FIND_BWD: begin
        if (len == 0) begin
          res.status = bdl_pkg::STAT_EMPTY;
        end else begin
          for (int unsigned d = 0; d < len; d++) begin
            if (!hit) begin
              if ((cmd == bdl_pkg::CMD_FIND_FWD && list_shadow[d] == val) ||
                  (cmd == bdl_pkg::CMD_FIND_BWD && list_shadow[len - 1 - d] == val)) begin
                hit          = 1'b1;
                res.distance = d[bdl_pkg::DistW-1:0];
              end
            end
          end
          if (!hit) res.status = bdl_pkg::STAT_NOTFOUND;
        end
      end
      default: ;
    endcase
    res.count = bdl_pkg::CountW'(list_shadow.size());
    return res;
  endfunction

  task automatic send_list_cmd(input logic [bdl_pkg::CmdW-1:0] cmd,
                               input logic [bdl_pkg::DataW-1:0] val,
                               input logic [bdl_pkg::PosW-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_list_cmd(cmd, val, pos));
  endtask

  // Drops valid and waits until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [bdl_pkg::DataW-1:0] pick_value();
    logic [bdl_pkg::DataW-1:0] extremes[4];
    extremes[0] = 32'h8000_0000;
    extremes[1] = 32'h7fff_ffff;
    extremes[2] = 32'h0000_0000;
    extremes[3] = 32'hffff_ffff;
    case ($urandom_range(3))
      0:       return (list_shadow.size() != 0) ?
                      list_shadow[$urandom_range(list_shadow.size() - 1)] : $urandom;
      1:       return $urandom_range(15) - 8;
      2:       return $urandom;
      default: return extremes[$urandom_range(3)];
    endcase
  endfunction

  function automatic logic [bdl_pkg::PosW-1:0] pick_position();
    if (list_shadow.size() != 0 && $urandom_range(99) < 85)
      return bdl_pkg::PosW'($urandom_range(list_shadow.size() - 1));
    return bdl_pkg::PosW'($urandom_range(63));
  endfunction

  task automatic test_empty_list();
    send_list_cmd(bdl_pkg::CMD_DELETE, $urandom, 6'd0);
    send_list_cmd(bdl_pkg::CMD_DELETE, $urandom, 6'd63);
    send_list_cmd(bdl_pkg::CMD_FIND_FWD, 32'h0000_0000, bdl_pkg::PosW'($urandom_range(63)));
    send_list_cmd(bdl_pkg::CMD_FIND_BWD, 32'hffff_ffff, bdl_pkg::PosW'($urandom_range(63)));
    for (int unsigned c = 5; c < 8; c++)
      send_list_cmd(bdl_pkg::CmdW'(c), $urandom, bdl_pkg::PosW'($urandom_range(63)));
  endtask

  task automatic test_directed_ops();
    send_list_cmd(bdl_pkg::CMD_INS_FRONT, 32'h8000_0000, 6'd0);
    send_list_cmd(bdl_pkg::CMD_INS_BACK,  32'h7fff_ffff, 6'd63);
    send_list_cmd(bdl_pkg::CMD_INS_FRONT, 32'h1234_5678, 6'd0);
    send_list_cmd(bdl_pkg::CMD_INS_BACK,  32'hffff_ffff, 6'd0);
    send_list_cmd(bdl_pkg::CMD_INS_BACK,  32'h1234_5678, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_FWD,  32'h7fff_ffff, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_BWD,  32'h8000_0000, 6'd0);
    // A value held at both ends gives distance zero from either end.
    send_list_cmd(bdl_pkg::CMD_FIND_FWD,  32'h1234_5678, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_BWD,  32'h1234_5678, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_FWD,  32'h0bad_cafe, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_BWD,  32'h0bad_cafe, 6'd0);
    send_list_cmd(bdl_pkg::CMD_DELETE,    $urandom, 6'd63);
    send_list_cmd(bdl_pkg::CMD_DELETE,    $urandom, bdl_pkg::PosW'(list_shadow.size()));
    send_list_cmd(bdl_pkg::CMD_DELETE,    $urandom, 6'd2);
    send_list_cmd(bdl_pkg::CMD_DELETE,    $urandom, bdl_pkg::PosW'(list_shadow.size() - 1));
    while (list_shadow.size() != 0) send_list_cmd(bdl_pkg::CMD_DELETE, $urandom, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_BWD,  32'h8000_0000, 6'd0);
  endtask

  task automatic test_full_list();
    while (list_shadow.size() < LIST_CAP)
      send_list_cmd($urandom_range(1) ? bdl_pkg::CMD_INS_FRONT : bdl_pkg::CMD_INS_BACK,
                    $urandom, bdl_pkg::PosW'($urandom_range(63)));
    send_list_cmd(bdl_pkg::CMD_INS_FRONT, $urandom, 6'd0);
    send_list_cmd(bdl_pkg::CMD_INS_BACK, $urandom, 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_FWD, list_shadow[LIST_CAP - 1], 6'd0);
    send_list_cmd(bdl_pkg::CMD_FIND_BWD, list_shadow[0], 6'd0);
    send_list_cmd(bdl_pkg::CMD_DELETE, $urandom, 6'd63);
    send_list_cmd(bdl_pkg::CMD_INS_BACK, $urandom, 6'd0);
    while (list_shadow.size() != 0)
      send_list_cmd(bdl_pkg::CMD_DELETE, $urandom,
                    bdl_pkg::PosW'($urandom_range(list_shadow.size() - 1)));
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    logic [bdl_pkg::CmdW-1:0] cmd;
    int unsigned              pick;
    for (int unsigned i = 0; i < n_items; i++) begin
      // Swing the fill level between empty and full so both ends are visited.
      if (list_shadow.size() >= LIST_CAP) grow_mode = 1'b0;
      else if (list_shadow.size() == 0) grow_mode = 1'b1;
      else if ($urandom_range(99) < 2) grow_mode = ~grow_mode;
      pick = $urandom_range(99);
      if (pick < 2) cmd = bdl_pkg::CmdW'(5 + $urandom_range(2));
      else if (pick < (grow_mode ? 50 : 22))
        cmd = $urandom_range(1) ? bdl_pkg::CMD_INS_FRONT : bdl_pkg::CMD_INS_BACK;
      else if (pick < 70) cmd = bdl_pkg::CMD_DELETE;
      else cmd = $urandom_range(1) ? bdl_pkg::CMD_FIND_FWD : bdl_pkg::CMD_FIND_BWD;
      send_list_cmd(cmd, pick_value(), pick_position());
    end
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < receiver_stall_pct);

  always @(posedge clk_i) begin : result_check
    list_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d count %0d",
                                  status_o, entry_count_o));
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status_o, exp_r.status));
        if (match_distance_o !== exp_r.distance)
          report_mismatch($sformatf("match_distance %0d, predicted %0d",
                                    match_distance_o, exp_r.distance));
        if (entry_count_o !== exp_r.count)
          report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                    entry_count_o, exp_r.count));
      end
    end
  end

  // Any transaction on either side counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_directed_ops();
    wait_for_results();

    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    test_full_list();
    wait_for_results();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_traffic(PHASE_ITEMS);
    wait_for_results();

    sender_idle_pct    = 53;
    receiver_stall_pct = 0;
    test_random_traffic(PHASE_ITEMS);
    wait_for_results();

    sender_idle_pct    = 0;
    receiver_stall_pct = 53;
    test_random_traffic(PHASE_ITEMS);
    wait_for_results();

    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    test_random_traffic(PHASE_ITEMS);
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
